// ===== rtl/dds_pkg.sv =====
// Shared types and constants for the dirty-span panel refresh block.
// Used by dds_front, dds_back and the top level; depends on nothing.
package dds_pkg;

    // Input operation codes
    typedef enum logic {
        OP_SCAN  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_WIDTH = 2'd0;
    localparam logic [1:0] CFG_IDX_PAGES = 2'd1;

    // Reset values of the configuration registers
    localparam logic [7:0] CFG_WIDTH_RST = 8'd128;
    localparam logic [3:0] CFG_PAGES_RST = 4'd8;

    // Panel command bytes and masks
    localparam logic [7:0] CMD_COL_HI    = 8'h10;
    localparam logic [7:0] COL_LO_MASK   = 8'h0F;
    localparam logic [7:0] CMD_PAGE      = 8'hB0;
    localparam logic [7:0] FULL_WIDTH    = 8'd132;
    localparam logic [7:0] COL_OFFSET    = 8'd2;
    localparam logic [7:0] SHADOW_RESET  = 8'hFF;

    // Queue depths between front, back and the result port
    localparam int CMD_DEPTH    = 2;
    localparam int RESULT_DEPTH = 4;

    // Classified item handed from front to back
    typedef struct packed {
        t_op        op;
        logic [2:0] page;
        logic [7:0] column;
        logic [7:0] pixel;
        logic       in_range;
        logic       last_col;
    } t_cmd;

    // One result transaction
    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last;
    } t_result;

endpackage

// ===== rtl/dds_fifo.sv =====
// Small synchronous FIFO of a generic payload type.
// Depends on nothing; used for the command queue and the result queue.
module dds_fifo #(
    parameter type T     = logic [7:0],
    parameter int  DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  T                             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output T                             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/dds_front.sv =====
// Front end: configuration registers and classification of incoming items.
// Depends on dds_pkg; feeds the command queue read by dds_back.
module dds_front
    import dds_pkg::*;
#(
    parameter int MAX_COLUMNS = 132,
    parameter int MAX_PAGES   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_op,
    input  logic [2:0] i_page,
    input  logic [7:0] i_column,
    input  logic [7:0] i_pixel_byte,
    output t_cmd       o_cmd,
    output logic       o_full_width
);

    logic [7:0] r_width_in_use;
    logic [3:0] r_page_count;
    logic [7:0] eff_width;
    logic [3:0] eff_pages;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_in_use <= CFG_WIDTH_RST;
            r_page_count   <= CFG_PAGES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_WIDTH: r_width_in_use <= i_cfg_wdata;
                CFG_IDX_PAGES: r_page_count   <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Clamp the registers to the supported geometry
    always_comb begin
        eff_width = r_width_in_use;
        if (eff_width == 8'd0) begin
            eff_width = 8'd1;
        end else if (eff_width > 8'(MAX_COLUMNS)) begin
            eff_width = 8'(MAX_COLUMNS);
        end
        eff_pages = r_page_count;
        if (eff_pages == 4'd0) begin
            eff_pages = 4'd1;
        end else if (eff_pages > 4'(MAX_PAGES)) begin
            eff_pages = 4'(MAX_PAGES);
        end
    end

    assign o_full_width = (eff_width == FULL_WIDTH);

    // Classify the incoming item
    always_comb begin
        o_cmd.op       = t_op'(i_op);
        o_cmd.page     = i_page;
        o_cmd.column   = i_column;
        o_cmd.pixel    = i_pixel_byte;
        o_cmd.in_range = ({1'b0, i_page} < eff_pages) && (i_column < eff_width);
        o_cmd.last_col = (i_column == eff_width - 8'd1);
    end

endmodule

// ===== rtl/dds_back.sv =====
// Back end: shadow store, span tracking, transmission sequencer, result queue.
// Depends on dds_pkg and dds_fifo; pops classified items from the command queue.
module dds_back
    import dds_pkg::*;
#(
    parameter int MAX_COLUMNS = 132,
    parameter int MAX_PAGES   = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_head,
    input  logic    i_q_empty,
    output logic    o_q_pop,
    input  logic    i_full_width,
    output logic    o_clearing,
    input  logic    i_res_pop,
    output t_result o_res,
    output logic    o_res_empty
);

    localparam int MEM_DEPTH = MAX_COLUMNS * MAX_PAGES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int RES_CNT_W = $clog2(RESULT_DEPTH + 1);

    localparam logic [7:0] STEP_COL_HI = 8'd0;
    localparam logic [7:0] STEP_COL_LO = 8'd1;
    localparam logic [7:0] STEP_PAGE   = 8'd2;
    localparam logic [8:0] STEP_DATA0  = 9'd3;

    // Column of a data byte for a given step, held to the last column
    function automatic logic [7:0] data_col(input logic [7:0] first, input logic [7:0] step);
        logic [8:0] col;
        col = {1'b0, first} + {1'b0, step} - STEP_DATA0;
        if (col > 9'(MAX_COLUMNS - 1)) begin
            col = 9'(MAX_COLUMNS - 1);
        end
        return col[7:0];
    endfunction

    logic [7:0]        r_shadow [MEM_DEPTH];
    logic [7:0]        r_rd_data;
    logic              r_fwd_hit;
    logic [7:0]        r_fwd_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_b_valid;
    t_cmd              r_b_cmd;
    logic [ADDR_W-1:0] r_b_addr;

    logic [7:0]        r_span_first, n_span_first;
    logic [7:0]        r_span_last,  n_span_last;
    logic              r_span_seen,  n_span_seen;
    logic [2:0]        r_pending_page, n_pending_page;
    logic              r_busy,       n_busy;
    logic [7:0]        r_step,       n_step;

    logic [RES_CNT_W-1:0] res_count;
    logic              res_full;
    logic              res_valid;
    t_result           res;

    logic              step_inc;
    logic [7:0]        step_after;
    logic [ADDR_W-1:0] scan_addr;
    logic [ADDR_W-1:0] drain_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              b_we;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        shadow_q;
    logic              changed;
    logic [7:0]        start_col;
    logic [7:0]        b_col;

    // Pop only when the result queue has room for everything in flight
    assign o_q_pop = !i_q_empty && !r_clearing &&
                     (({1'b0, res_count} + (RES_CNT_W + 1)'(r_b_valid))
                      < (RES_CNT_W + 1)'(RESULT_DEPTH));
    assign o_clearing = r_clearing;

    // Read address: scan byte, or the data byte the next drain will need
    assign step_inc   = r_b_valid && (r_b_cmd.op == OP_DRAIN) && r_busy;
    assign step_after = r_step + 8'(step_inc);
    assign scan_addr  = ADDR_W'(i_head.page) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(i_head.column);
    assign drain_addr = ADDR_W'(r_pending_page) * ADDR_W'(MAX_COLUMNS)
                      + ADDR_W'(data_col(r_span_first, step_after));
    assign rd_addr    = (i_head.op == OP_SCAN) ? scan_addr : drain_addr;

    // Write port: clearing sweep or scan update
    assign b_we    = r_b_valid && (r_b_cmd.op == OP_SCAN) && !r_busy && r_b_cmd.in_range;
    assign mem_we  = r_clearing || b_we;
    assign wr_addr = r_clearing ? r_clr_addr : r_b_addr;
    assign wr_data = r_clearing ? SHADOW_RESET : r_b_cmd.pixel;

    // Shadow memory, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_shadow[wr_addr] <= wr_data;
        end
        if (o_q_pop) begin
            r_rd_data <= r_shadow[rd_addr];
        end
    end

    // Bypass a write that lands on the address being read
    always_ff @(posedge i_clk) begin
        r_fwd_data <= r_b_cmd.pixel;
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (o_q_pop) begin
            r_fwd_hit <= b_we && (r_b_addr == rd_addr);
        end
    end

    assign shadow_q = r_fwd_hit ? r_fwd_data : r_rd_data;

    // Sweep the shadow store to its reset value after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Hold the popped item for the execute stage
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b_cmd  <= i_head;
            r_b_addr <= scan_addr;
        end
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= o_q_pop;
        end
    end

    assign changed   = (shadow_q != r_b_cmd.pixel);
    assign start_col = r_span_first + (i_full_width ? 8'd0 : COL_OFFSET);
    assign b_col     = data_col(r_span_first, r_step);

    // Execute: span tracking, arming and transmission steps
    always_comb begin
        n_span_first   = r_span_first;
        n_span_last    = r_span_last;
        n_span_seen    = r_span_seen;
        n_pending_page = r_pending_page;
        n_busy         = r_busy;
        n_step         = r_step;
        res_valid      = 1'b0;
        res.kind       = KIND_CMD;
        res.out_byte   = 8'd0;
        res.last       = 1'b0;
        if (r_b_valid) begin
            if (r_b_cmd.op == OP_SCAN) begin
                if (r_busy) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_REJECT;
                end else if (r_b_cmd.in_range) begin
                    if (changed) begin
                        if (!r_span_seen) begin
                            n_span_first = r_b_cmd.column;
                            n_span_last  = r_b_cmd.column;
                            n_span_seen  = 1'b1;
                        end else begin
                            if (r_b_cmd.column < r_span_first) begin
                                n_span_first = r_b_cmd.column;
                            end
                            if (r_b_cmd.column > r_span_last) begin
                                n_span_last = r_b_cmd.column;
                            end
                        end
                    end
                    if (r_b_cmd.last_col) begin
                        if (n_span_seen) begin
                            n_busy         = 1'b1;
                            n_step         = 8'd0;
                            n_pending_page = r_b_cmd.page;
                        end
                        n_span_seen = 1'b0;
                    end
                end
            end else if (r_busy) begin
                res_valid = 1'b1;
                n_step    = r_step + 8'd1;
                case (r_step)
                    STEP_COL_HI: res.out_byte = CMD_COL_HI | {4'd0, start_col[7:4]};
                    STEP_COL_LO: res.out_byte = start_col & COL_LO_MASK;
                    STEP_PAGE:   res.out_byte = CMD_PAGE | {5'd0, r_pending_page};
                    default: begin
                        res.kind     = KIND_DATA;
                        res.out_byte = shadow_q;
                        res.last     = (b_col >= r_span_last);
                        if (res.last) begin
                            n_busy = 1'b0;
                            n_step = 8'd0;
                        end
                    end
                endcase
            end
        end
    end

    // Hold span and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_first   <= '0;
            r_span_last    <= '0;
            r_span_seen    <= 1'b0;
            r_pending_page <= '0;
            r_busy         <= 1'b0;
            r_step         <= '0;
        end else begin
            r_span_first   <= n_span_first;
            r_span_last    <= n_span_last;
            r_span_seen    <= n_span_seen;
            r_pending_page <= n_pending_page;
            r_busy         <= n_busy;
            r_step         <= n_step;
        end
    end

    // Result queue toward the output port
    dds_fifo #(
        .T     (t_result),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_data  (o_res),
        .o_empty (o_res_empty),
        .o_count (res_count)
    );

    // Credit check must keep the result queue from overflowing
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !res_full)
        else $error("result pushed into a full queue");

    // No item is taken while the shadow store is being swept
    a_no_pop_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_q_pop)
        else $error("item popped during clearing sweep");

    // Span bounds stay ordered
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_span_first <= r_span_last)
        else $error("span first column beyond last column");

    // A fresh span cannot open while a transmission is pending
    a_busy_no_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_span_seen)
        else $error("span tracking active during transmission");

    // Scan writes stay inside the shadow store
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_we |-> (r_b_addr < ADDR_W'(MEM_DEPTH - 1)) || (r_b_addr == ADDR_W'(MEM_DEPTH - 1)))
        else $error("shadow write outside the store");

endmodule

// ===== rtl/display_dirty_span_refresh_top.sv =====
// Top level of the dirty-span panel refresh block.
// Depends on dds_pkg, dds_front, dds_fifo and dds_back.
//
// Scan and drain items enter through push/full and results leave through
// empty/pop; one item is taken per clock cycle in steady state while full is
// low. An item passes through the command queue, the registered read of the
// single shadow memory and the execute stage that updates the span and
// transmission state before its result shows on the output queue. After reset
// the shadow store (MAX_COLUMNS * MAX_PAGES bytes, 1056 by default) is swept to
// 0xFF one byte per cycle, and full stays high for the whole sweep;
// configuration writes are taken during the sweep. full also rises when the
// result queue backs up through the command queue.
module display_dirty_span_refresh_top
    import dds_pkg::*;
#(
    parameter int MAX_COLUMNS = 132,
    parameter int MAX_PAGES   = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic       i_op,
    input  logic [2:0] i_page,
    input  logic [7:0] i_column,
    input  logic [7:0] i_pixel_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_page
);

    localparam int CMDQ_CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd    front_cmd;
    t_cmd    q_head;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic    full_width;
    logic    clearing;
    t_result res;
    logic [CMDQ_CNT_W-1:0] q_count;

    assign full = q_full || clearing;

    // Classify items and hold configuration
    dds_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (i_op),
        .i_page       (i_page),
        .i_column     (i_column),
        .i_pixel_byte (i_pixel_byte),
        .o_cmd        (front_cmd),
        .o_full_width (full_width)
    );

    // Decouple front and back
    dds_fifo #(
        .T     (t_cmd),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // Execute items against the shadow store and sequencer
    dds_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_full_width (full_width),
        .o_clearing   (clearing),
        .i_res_pop    (pop),
        .o_res        (res),
        .o_res_empty  (empty)
    );

    assign o_kind         = res.kind;
    assign o_out_byte     = res.out_byte;
    assign o_last_of_page = res.last;

    // Command queue never holds more than its depth
    a_cmd_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CMDQ_CNT_W'(CMD_DEPTH))
        else $error("command queue count beyond its depth");

    // Hold off the sender while the shadow store is swept
    a_full_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> full)
        else $error("input open during clearing sweep");

    // A waiting result holds until it is popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable({o_kind, o_out_byte, o_last_of_page})))
        else $error("waiting result changed before pop");

endmodule
